### rtl/strm_pkg.sv
// Package with constants, types and helper functions of the sparse table range maximum unit.
`default_nettype none

package strm_pkg;

  localparam int unsigned MaxLen  = 1024;
  localparam int unsigned Levels  = 11;
  localparam int unsigned DataW   = 32;
  localparam int unsigned IdxW    = $clog2(MaxLen);
  localparam int unsigned CntW    = IdxW + 1;
  localparam int unsigned LvlW    = $clog2(Levels);
  localparam int unsigned AddrW   = LvlW + IdxW;
  localparam int unsigned MemDepth = Levels * MaxLen;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [LvlW-1:0]  lvl_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic signed [DataW-1:0] data_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_QUERY = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_BRA  = 7'b0000010,
    ST_BRB  = 7'b0000100,
    ST_BWR  = 7'b0001000,
    ST_QRA  = 7'b0010000,
    ST_QRB  = 7'b0100000,
    ST_QMX  = 7'b1000000
  } state_e;

  function automatic lvl_t floor_log2(input cnt_t x);
    lvl_t q;
    q = '0;
    for (int i = 0; i < CntW; i++) begin
      if (x[i]) begin
        q = LvlW'(i);
      end
    end
    return q;
  endfunction

  function automatic data_t smax(input data_t a, input data_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

### rtl/sparse_table_range_max_unit.sv
// Top level of the sparse table range maximum unit with its table memory and sequencer.
//
// Items arrive on a valid/ready input channel; each item gives exactly one result
// on a valid/ready output channel, held in an output register until its transfer.
// A load item writes one element into level zero of the table unless it is full;
// its result is presented in the cycle after the input transfer. A load flagged
// last with at least two elements held then starts the build, which walks the
// levels with a single memory read port and one shared signed comparator; each
// built entry takes two reads and a write, and no input is taken during the build.
// A query reads two table entries in turn in states QRA and QRB and registers their
// maximum into the output register from state QMX; a rejected query answers in the
// cycle after the input transfer, with no table read.
// The block takes one item at a time: ready is low while an item or a build is in
// progress, and also while a result waits because the receiver is stalling.
// Reset clears the element count and the built flag; the table memory itself is
// not cleared and needs no clearing pass.
`default_nettype none

module sparse_table_range_max_unit
  import strm_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    operation_i,
  input  wire logic signed [DataW-1:0] value_i,
  input  wire logic                    last_i,
  input  wire logic [IdxW-1:0]         left_i,
  input  wire logic [IdxW-1:0]         right_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [1:0]                   status_o,
  output logic signed [DataW-1:0]      result_o
);

  state_e state_q, state_d;
  cnt_t   count_q, count_d;
  logic   built_q, built_d;
  lvl_t   lvl_q, lvl_d;
  idx_t   idx_q, idx_d;
  data_t  a_q, a_d;
  addr_t  qa_q, qa_d, qb_q, qb_d;
  logic   out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  data_t  result_q, result_d;

  data_t  mem_q [MemDepth];
  data_t  rdata_q;
  addr_t  raddr;
  addr_t  waddr;
  data_t  wdata;
  logic   we;

  logic   accept;
  cnt_t   eff_cnt;
  cnt_t   new_cnt;
  cnt_t   span;
  cnt_t   nxt_idx;
  lvl_t   nxt_lvl;
  idx_t   half;
  cnt_t   qlen;
  lvl_t   qlvl;
  cnt_t   qb_idx;
  data_t  cmp_a, cmp_b, cmp_max;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign result_o    = result_q;

  assign cmp_max = smax(cmp_a, cmp_b);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    built_d     = built_q;
    lvl_d       = lvl_q;
    idx_d       = idx_q;
    a_d         = a_q;
    qa_d        = qa_q;
    qb_d        = qb_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    result_d    = result_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = value_i;
    raddr       = '0;
    cmp_a       = a_q;
    cmp_b       = rdata_q;
    eff_cnt     = built_q ? '0 : count_q;
    new_cnt     = eff_cnt;
    half        = IdxW'(1) << (lvl_q - LvlW'(1));
    span        = CntW'(1) << lvl_q;
    nxt_idx     = CntW'(idx_q) + CntW'(1);
    nxt_lvl     = lvl_q + LvlW'(1);
    qlen        = CntW'(right_i) - CntW'(left_i) + CntW'(1);
    qlvl        = floor_log2(qlen);
    if (qlvl > LvlW'(Levels - 1)) begin
      qlvl = LvlW'(Levels - 1);
    end
    qb_idx      = CntW'(right_i) + CntW'(1) - (CntW'(1) << qlvl);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_LOAD) begin
            built_d     = 1'b0;
            out_valid_d = 1'b1;
            result_d    = '0;
            if (eff_cnt < CntW'(MaxLen)) begin
              we       = 1'b1;
              waddr    = {LvlW'(0), eff_cnt[IdxW-1:0]};
              new_cnt  = eff_cnt + CntW'(1);
              status_d = STATUS_OK;
            end else begin
              status_d = STATUS_OVERFLOW;
            end
            count_d = new_cnt;
            if (last_i) begin
              if (new_cnt >= CntW'(2)) begin
                lvl_d   = LvlW'(1);
                idx_d   = '0;
                state_d = ST_BRA;
              end else begin
                built_d = 1'b1;
              end
            end
          end else begin
            if (!built_q || (left_i > right_i) || (CntW'(right_i) >= count_q)) begin
              out_valid_d = 1'b1;
              status_d    = STATUS_BAD_QUERY;
              result_d    = '0;
            end else begin
              qa_d    = {qlvl, left_i};
              qb_d    = {qlvl, qb_idx[IdxW-1:0]};
              state_d = ST_QRA;
            end
          end
        end
      end
      ST_BRA: begin
        raddr   = {lvl_q - LvlW'(1), idx_q};
        state_d = ST_BRB;
      end
      ST_BRB: begin
        raddr   = {lvl_q - LvlW'(1), idx_q + half};
        a_d     = rdata_q;
        state_d = ST_BWR;
      end
      ST_BWR: begin
        we    = 1'b1;
        waddr = {lvl_q, idx_q};
        wdata = cmp_max;
        if ((CntW + 1)'(nxt_idx) + (CntW + 1)'(span) <= (CntW + 1)'(count_q)) begin
          idx_d   = nxt_idx[IdxW-1:0];
          state_d = ST_BRA;
        end else if ((nxt_lvl < LvlW'(Levels)) &&
                     (((CntW + 1)'(1) << nxt_lvl) <= (CntW + 1)'(count_q))) begin
          lvl_d   = nxt_lvl;
          idx_d   = '0;
          state_d = ST_BRA;
        end else begin
          built_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_QRA: begin
        raddr   = qa_q;
        state_d = ST_QRB;
      end
      ST_QRB: begin
        raddr   = qb_q;
        a_d     = rdata_q;
        state_d = ST_QMX;
      end
      ST_QMX: begin
        out_valid_d = 1'b1;
        status_d    = STATUS_OK;
        result_d    = cmp_max;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      built_q     <= built_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q    <= lvl_d;
    idx_q    <= idx_d;
    a_q      <= a_d;
    qa_q     <= qa_d;
    qb_q     <= qb_d;
    status_q <= status_d;
    result_q <= result_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the sparse table range maximum unit with a scoreboard class.
module tb_top
  import strm_pkg::*;
();

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 40;

  typedef struct packed {
    status_e status;
    data_t   result;
  } range_answer_t;

  class range_max_scoreboard;
    data_t         level_tbl [Levels][MaxLen];
    int unsigned   loaded_len;
    bit            built;
    range_answer_t answer_q [$];
    int unsigned   errors;

    function new();
      loaded_len = 0;
      built      = 1'b0;
      errors     = 0;
    endfunction

    function data_t larger(data_t a, data_t b);
      return (a > b) ? a : b;
    endfunction

    function void build_levels();
      int unsigned half;
      for (int j = 1; j < Levels; j++) begin
        half = 1 << (j - 1);
        if (2 * half > loaded_len) begin
          break;
        end
        for (int i = 0; i + 2 * half <= loaded_len; i++) begin
          level_tbl[j][i] = larger(level_tbl[j-1][i], level_tbl[j-1][i+half]);
        end
      end
      built = 1'b1;
    endfunction

    function void note_input(op_e op, data_t value, logic last, idx_t left, idx_t right);
      range_answer_t ans;
      int unsigned   span;
      int unsigned   lvl;
      ans.status = STATUS_OK;
      ans.result = '0;
      if (op == OP_LOAD) begin
        if (built) begin
          built      = 1'b0;
          loaded_len = 0;
        end
        if (loaded_len < MaxLen) begin
          level_tbl[0][loaded_len] = value;
          loaded_len++;
        end else begin
          ans.status = STATUS_OVERFLOW;
        end
        if (last) begin
          build_levels();
        end
      end else if (!built || left > right || right >= loaded_len) begin
        ans.status = STATUS_BAD_QUERY;
      end else begin
        span = right - left + 1;
        lvl  = 0;
        while (span > 1) begin
          span = span >> 1;
          lvl++;
        end
        if (lvl >= Levels) begin
          lvl = Levels - 1;
        end
        ans.result = larger(level_tbl[lvl][left], level_tbl[lvl][right + 1 - (1 << lvl)]);
      end
      answer_q.push_back(ans);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [1:0] status, data_t result);
      range_answer_t ans;
      if (answer_q.size() == 0) begin
        report_mismatch($sformatf("result %0d status %0d with nothing outstanding",
                                  result, status));
      end else begin
        ans = answer_q.pop_front();
        if (status !== ans.status) begin
          report_mismatch($sformatf("status %0d, wanted %0d", status, ans.status));
        end
        if (result !== ans.result) begin
          report_mismatch($sformatf("result %0d, wanted %0d", result, ans.result));
        end
      end
    endtask

    function int unsigned pending();
      return answer_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  data_t       value;
  logic        last_elem;
  idx_t        left_idx;
  idx_t        right_idx;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  data_t       result;

  range_max_scoreboard sb;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_req;
  int unsigned items_sent;
  int unsigned cycle_count;

  sparse_table_range_max_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .operation_i (operation),
    .value_i     (value),
    .last_i      (last_elem),
    .left_i      (left_idx),
    .right_i     (right_idx),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .result_o    (result)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(status, result);
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(op_e op, data_t val, logic lst, idx_t lft, idx_t rgt);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid  = 1'b1;
    operation = op;
    value     = val;
    last_elem = lst;
    left_idx  = lft;
    right_idx = rgt;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    sb.note_input(op, val, lst, lft, rgt);
    items_sent++;
  endtask

  task automatic load_elem(data_t val, logic lst);
    send_item(OP_LOAD, val, lst, idx_t'($urandom), idx_t'($urandom));
  endtask

  task automatic ask_range(int unsigned lft, int unsigned rgt);
    send_item(OP_QUERY, data_t'($urandom), logic'($urandom), idx_t'(lft), idx_t'(rgt));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic data_t rand_value();
    case ($urandom_range(0, 7))
      0: return data_t'(32'h8000_0000);
      1: return data_t'(32'h7fff_ffff);
      2, 3: return data_t'(int'($urandom_range(0, 6)) - 3);
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic random_queries(int unsigned count);
    int unsigned lft;
    int unsigned rgt;
    for (int k = 0; k < count; k++) begin
      if (sb.built && sb.loaded_len > 0 && $urandom_range(0, 5) != 0) begin
        if ($urandom_range(0, 7) == 0) begin
          lft = 0;
          rgt = sb.loaded_len - 1;
        end else begin
          lft = $urandom_range(0, sb.loaded_len - 1);
          rgt = $urandom_range(lft, sb.loaded_len - 1);
        end
      end else begin
        lft = $urandom_range(0, MaxLen - 1);
        rgt = $urandom_range(0, MaxLen - 1);
      end
      ask_range(lft, rgt);
    end
  endtask

  task automatic small_table_run();
    int unsigned n;
    bit          broken;
    case ($urandom_range(0, 9))
      0: n = 1;
      1: n = $urandom_range(33, 64);
      default: n = $urandom_range(2, 16);
    endcase
    broken = ($urandom_range(0, 7) == 0);
    for (int e = 0; e < n; e++) begin
      load_elem(rand_value(), !broken && (e == n - 1));
    end
    random_queries($urandom_range(2, 12));
  endtask

  task automatic capacity_run();
    for (int e = 0; e < MaxLen; e++) begin
      load_elem(rand_value(), 1'b0);
    end
    load_elem(rand_value(), 1'b0);
    load_elem(rand_value(), 1'b0);
    load_elem(rand_value(), 1'b1);
    ask_range(0, MaxLen - 1);
    ask_range(MaxLen - 1, MaxLen - 1);
    ask_range(0, 0);
    ask_range(MaxLen / 2 - 1, MaxLen / 2);
    ask_range(1, MaxLen - 2);
    random_queries(24);
  endtask

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    operation   = OP_LOAD;
    value       = '0;
    last_elem   = 1'b0;
    left_idx    = '0;
    right_idx   = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b0;
    items_sent  = 0;
    cycle_count = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    ask_range(0, 0);
    ask_range(MaxLen - 1, MaxLen - 1);
    load_elem(data_t'(32'h8000_0000), 1'b1);
    ask_range(0, 0);
    ask_range(0, 1);
    ask_range(1, 0);
    load_elem(data_t'(32'h7fff_ffff), 1'b0);
    load_elem(data_t'(-1), 1'b0);
    load_elem(data_t'(0), 1'b0);
    load_elem(data_t'(32'h8000_0000), 1'b0);
    load_elem(data_t'(5), 1'b1);
    ask_range(0, 4);
    ask_range(1, 4);
    ask_range(3, 3);
    ask_range(1, 2);
    ask_range(2, 3);
    ask_range(4, 1);
    ask_range(0, MaxLen - 1);
    ask_range(MaxLen - 1, 0);
    ask_range(5, 5);

    tx_idle_pct = 17;
    rx_idle_pct = 79;
    while (items_sent < 60) begin
      small_table_run();
    end
    wait_drained();

    tx_idle_pct = 79;
    rx_idle_pct = 17;
    while (items_sent < 110) begin
      small_table_run();
    end
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 1'b1;
    capacity_run();
    while (items_sent < 1150) begin
      small_table_run();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sparse_table_range_max_unit.f
rtl/strm_pkg.sv
rtl/sparse_table_range_max_unit.sv
tb/tb_top.sv
